@@ hw/rtl/ffd_pkg.sv @@
package ffd_pkg;

  // Filter size and derived widths
  localparam int TAPS     = 64;
  localparam int RING_LEN = TAPS + 1;
  localparam int PTR_W    = $clog2(RING_LEN);
  localparam int TIDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int STEP_W   = $clog2(TAPS + 1);

  // Field formats
  localparam int OPC_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 17;
  localparam int IDX_W    = 6;
  localparam int COEF_W   = 18;
  localparam int OUT_W    = 39;

  // Datapath widths: interpolated sample fits 32 bits signed
  localparam int MIX_W  = 32;
  localparam int PROD_W = COEF_W + MIX_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int EXT_W  = (ACC_W > OUT_W + 16) ? ACC_W : OUT_W + 16;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE_TAP   = 2'd0,
    OP_PUSH_FILTER = 2'd1,
    OP_PUSH        = 2'd2,
    OP_FILTER      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              ring_we;
    logic [PTR_W-1:0]  ring_waddr;
    logic              ring_re;
    logic [PTR_W-1:0]  ring_raddr;
    logic              tap_we;
    logic [TIDX_W-1:0] tap_waddr;
    logic              tap_re;
    logic [TIDX_W-1:0] tap_raddr;
  } mem_ctl_t;

  typedef struct packed {
    logic start;      // latch fraction for a new filter pass
    logic issue;      // sample read issued this cycle
    logic mix_en;     // this read completes a tap pair
    logic first_tap;  // pair belongs to tap 0
    logic load_out;   // move accumulator into result register
  } mac_ctl_t;

endpackage

@@ hw/rtl/ffd_if.sv @@
interface ffd_req_if;
  logic                                valid;
  logic                                ready;
  logic        [ffd_pkg::OPC_W-1:0]    opcode;
  logic signed [ffd_pkg::SAMPLE_W-1:0] sample;
  logic        [ffd_pkg::FRAC_W-1:0]   frac_offset;
  logic        [ffd_pkg::IDX_W-1:0]    tap_index;
  logic signed [ffd_pkg::COEF_W-1:0]   tap_value;

  modport source (
    output valid, opcode, sample, frac_offset, tap_index, tap_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, sample, frac_offset, tap_index, tap_value,
    output ready
  );
endinterface

interface ffd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [ffd_pkg::OUT_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

@@ hw/rtl/ffd_sample_ring.sv @@
module ffd_sample_ring (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic        [ffd_pkg::PTR_W-1:0]    waddr,
  input  logic signed [ffd_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                re,
  input  logic        [ffd_pkg::PTR_W-1:0]    raddr,
  output logic signed [ffd_pkg::SAMPLE_W-1:0] rdata
);
  import ffd_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [RING_LEN];
  logic        [RING_LEN-1:0] written;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_q <= written[raddr];
      end
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

@@ hw/rtl/ffd_tap_store.sv @@
module ffd_tap_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic        [ffd_pkg::TIDX_W-1:0] waddr,
  input  logic signed [ffd_pkg::COEF_W-1:0] wdata,
  input  logic                              re,
  input  logic        [ffd_pkg::TIDX_W-1:0] raddr,
  output logic signed [ffd_pkg::COEF_W-1:0] rdata
);
  import ffd_pkg::*;

  logic signed [COEF_W-1:0] mem [TAPS];
  logic        [TAPS-1:0]   written;
  logic signed [COEF_W-1:0] rdata_q;
  logic                     rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_q <= written[raddr];
      end
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

@@ hw/rtl/ffd_mac_unit.sv @@
module ffd_mac_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  ffd_pkg::mac_ctl_t                   ctl,
  input  logic        [ffd_pkg::FRAC_W-1:0]   frac_offset,
  input  logic signed [ffd_pkg::SAMPLE_W-1:0] sample_rd,
  input  logic signed [ffd_pkg::COEF_W-1:0]   tap_rd,
  output logic signed [ffd_pkg::OUT_W-1:0]    filtered
);
  import ffd_pkg::*;

  logic        [FRAC_W-1:0]   frac_q;
  logic                       p1_issue;
  logic                       p1_mix;
  logic                       p1_first;
  logic                       p2_v;
  logic                       p2_first;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_W+SAMPLE_W+1:0] diff_prod;
  logic signed [MIX_W+3:0]    mix_wide;
  logic signed [MIX_W-1:0]    mix_q;
  logic signed [COEF_W-1:0]   tap_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [EXT_W-1:0]    acc_ext;
  logic signed [OUT_W-1:0]    filtered_q;

  // s[a]*(1-f) + s[b]*f == s[a]*ONE + (s[b]-s[a])*f
  assign diff      = (SAMPLE_W+1)'(sample_rd) - (SAMPLE_W+1)'(prev_q);
  assign diff_prod = diff * $signed({1'b0, frac_q});
  assign mix_wide  = ((MIX_W+4)'(prev_q) <<< 16) + (MIX_W+4)'(diff_prod);
  assign prod      = tap_q * mix_q;
  assign acc_ext   = EXT_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_issue <= 1'b0;
      p1_mix   <= 1'b0;
      p1_first <= 1'b0;
      p2_v     <= 1'b0;
      p2_first <= 1'b0;
    end else begin
      p1_issue <= ctl.issue;
      p1_mix   <= ctl.mix_en;
      p1_first <= ctl.first_tap;
      p2_v     <= p1_mix;
      p2_first <= p1_first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      frac_q <= (frac_offset > FRAC_ONE) ? FRAC_ONE : frac_offset;
    end
    if (p1_issue) begin
      prev_q <= sample_rd;
    end
    if (p1_mix) begin
      mix_q <= mix_wide[MIX_W-1:0];
      tap_q <= tap_rd;
    end
    if (p2_v) begin
      acc <= (p2_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
    if (ctl.load_out) begin
      filtered_q <= acc_ext[16 +: OUT_W];  // arithmetic shift, floor
    end
  end

  assign filtered = filtered_q;

endmodule

@@ hw/rtl/ffd_sequencer.sv @@
module ffd_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [ffd_pkg::OPC_W-1:0]    opcode,
  input  logic [ffd_pkg::IDX_W-1:0]    tap_index,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output ffd_pkg::mem_ctl_t            mem_ctl,
  output ffd_pkg::mac_ctl_t            mac_ctl
);
  import ffd_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_m1;
  logic [PTR_W-1:0]  write_pos;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  rd_inc;
  opcode_t           op;
  logic              accept;
  logic              is_push;
  logic              is_filt;
  logic              out_free;
  logic              last_step;

  assign op        = opcode_t'(opcode);
  assign accept    = req_valid && req_ready;
  assign is_push   = (op == OP_PUSH_FILTER) || (op == OP_PUSH);
  assign is_filt   = (op == OP_PUSH_FILTER) || (op == OP_FILTER);
  assign out_free  = !rsp_valid || rsp_ready;
  assign last_step = (step == STEP_W'(TAPS));
  assign step_m1   = step - STEP_W'(1);
  assign wp_inc    = (write_pos == PTR_W'(RING_LEN - 1)) ? '0 : write_pos + PTR_W'(1);
  assign rd_inc    = (rd_ptr == PTR_W'(RING_LEN - 1)) ? '0 : rd_ptr + PTR_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_filt) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (step == STEP_W'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready          = (state == ST_IDLE);
    mem_ctl.ring_we    = accept && is_push;
    mem_ctl.ring_waddr = write_pos;
    mem_ctl.ring_re    = (state == ST_RUN);
    mem_ctl.ring_raddr = rd_ptr;
    mem_ctl.tap_we     = accept && (op == OP_WRITE_TAP) && (32'(tap_index) < 32'(TAPS));
    mem_ctl.tap_waddr  = TIDX_W'(tap_index);
    mem_ctl.tap_re     = (state == ST_RUN) && (step != '0);
    mem_ctl.tap_raddr  = TIDX_W'(step_m1);
    mac_ctl.start      = accept && is_filt;
    mac_ctl.issue      = (state == ST_RUN);
    mac_ctl.mix_en     = (state == ST_RUN) && (step != '0);
    mac_ctl.first_tap  = (state == ST_RUN) && (step == STEP_W'(1));
    mac_ctl.load_out   = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      write_pos <= '0;
      rd_ptr    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_RUN:   step <= last_step ? '0 : step + STEP_W'(1);
        ST_FLUSH: step <= step + STEP_W'(1);
        default:  step <= '0;
      endcase
      if (accept && is_push) begin
        write_pos <= wp_inc;
      end
      if (accept && is_filt) begin
        rd_ptr <= is_push ? wp_inc : write_pos;
      end else if (state == ST_RUN) begin
        rd_ptr <= rd_inc;
      end
      if (mac_ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    write_pos <= PTR_W'(RING_LEN - 1))
    else $error("write position out of ring");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= PTR_W'(RING_LEN - 1))
    else $error("read pointer out of ring");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.load_out |-> (!rsp_valid || rsp_ready))
    else $error("pending result overwritten");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.load_out |-> (!$past(mac_ctl.issue, 1) && !$past(mac_ctl.issue, 2)))
    else $error("result loaded before MAC pipeline drained");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (!mem_ctl.ring_we && !mem_ctl.tap_we))
    else $error("store written during filter pass");

endmodule

@@ hw/rtl/fir_fractional_delay_filter_unit.sv @@
// Channel | Dir  | Payload                                              | Transaction
// req     | sink | opcode, sample, frac_offset, tap_index, tap_value    | valid && ready
// rsp     | src  | filtered (39b signed)                                | valid && ready
//
// Tap writes and push-only transactions leave the sequencer idle; req stays ready.
// A filter transaction walks TAPS+1 ring reads through one shared
// interpolate/multiply-accumulate unit: req drops after the accept, and the
// result lands in the rsp register as req comes back, so a new filter
// transaction is accepted only once the last one's result is loaded.
// Synchronous reset clears valid bits of both stores at once; no clearing pass.
// A result waiting on rsp does not block new transactions; a second result
// holds in the sequencer's final state until the rsp register frees.
module fir_fractional_delay_filter_unit (
  input logic clk,
  input logic rst,
  ffd_req_if.sink   req,
  ffd_rsp_if.source rsp
);
  import ffd_pkg::*;

  mem_ctl_t                   mem_ctl;
  mac_ctl_t                   mac_ctl;
  logic signed [SAMPLE_W-1:0] sample_rd;
  logic signed [COEF_W-1:0]   tap_rd;

  // Control: handshakes, write position, read pointer, step count
  ffd_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .opcode    (req.opcode),
    .tap_index (req.tap_index),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .mem_ctl   (mem_ctl),
    .mac_ctl   (mac_ctl)
  );

  // Sample ring: written on push, read one entry per step from the oldest sample
  ffd_sample_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_ctl.ring_we),
    .waddr (mem_ctl.ring_waddr),
    .wdata (req.sample),
    .re    (mem_ctl.ring_re),
    .raddr (mem_ctl.ring_raddr),
    .rdata (sample_rd)
  );

  // Coefficients: read one step behind the ring so they line up with each pair
  ffd_tap_store u_taps (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_ctl.tap_we),
    .waddr (mem_ctl.tap_waddr),
    .wdata (req.tap_value),
    .re    (mem_ctl.tap_re),
    .raddr (mem_ctl.tap_raddr),
    .rdata (tap_rd)
  );

  // Shared unit: interpolation multiply, then coefficient multiply-accumulate
  ffd_mac_unit u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mac_ctl),
    .frac_offset (req.frac_offset),
    .sample_rd   (sample_rd),
    .tap_rd      (tap_rd),
    .filtered    (rsp.filtered)
  );

endmodule
